// ----- sv/node_reservation_lock_table_macros.svh -----
// Assertion macros used by the node reservation lock table sequencer.
// No dependencies; included by the files that carry assertions.
`ifndef NODE_RESERVATION_LOCK_TABLE_MACROS_SVH
`define NODE_RESERVATION_LOCK_TABLE_MACROS_SVH

// An implication that must hold on the same clock edge.
`define NRLT_ASSERT_IMP(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");

// An implication whose consequence must hold on the next clock edge.
`define NRLT_ASSERT_NXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");

`endif

// ----- sv/nrlt_pkg.sv -----
// Package for the node reservation lock table: item and result types,
// opcodes, sequencer states and fixed sizes. No dependencies.
package nrlt_pkg;

   localparam int NODES   = 256;
   localparam int NODE_W  = 8;
   localparam int ROBOTS  = 16;
   localparam int ROBOT_W = 4;
   localparam int ENTRY_W = 1 + ROBOT_W;
   localparam int ACT_W   = $clog2(ROBOTS + 1);
   localparam int TOT_W   = $clog2(NODES + 1);
   localparam int WIN_W   = 5;

   localparam logic [2:0] OP_RESERVE = 3'd0;
   localparam logic [2:0] OP_RELEASE = 3'd1;
   localparam logic [2:0] OP_QUERY   = 3'd2;
   localparam logic [2:0] OP_CHECK   = 3'd3;
   localparam logic [2:0] OP_DL_A    = 3'd4;
   localparam logic [2:0] OP_DL_B    = 3'd5;
   localparam logic [2:0] OP_CLEAR   = 3'd6;
   localparam logic [2:0] OP_UNUSED  = 3'd7;

   typedef struct packed {
      logic [2:0]         opcode;
      logic [ROBOT_W-1:0] robot_a;
      logic [ROBOT_W-1:0] other_robot;
      logic [NODE_W-1:0]  node_id;
      logic               node_valid;
      logic               last;
   } item_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic               accepted;
      logic               owner_valid;
      logic [ROBOT_W-1:0] owner_robot;
      logic               conflict;
      logic               deadlock;
      logic [ROBOT_W-1:0] loser_robot;
      logic [ACT_W-1:0]   robots_active;
      logic [TOT_W-1:0]   nodes_held;
      logic               result_last;
   } result_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_LOOK, ST_VER_RD, ST_VER_CHK, ST_FREE_HL,
      ST_FREE_ND, ST_FREE_WR, ST_COM_RD, ST_COM_WR, ST_RESP
   } state_type;

endpackage

// ----- sv/node_reservation_lock_table.sv -----
// Top level of the node reservation lock table: stream ports, window
// register and result register. Depends on nrlt_pkg and nrlt_seq.

// One transaction is handled at a time. Query and check items, and a DL_B
// element that is last, take a node-table lookup and then the result; other
// deadlock-list items and a reserve element that is not last take only the
// lookup. A reserve on its last element then verifies each buffered node,
// frees each node the robot held (held-list read, node read, node write)
// and commits each buffered node; release and a deadlock win run the same
// free walk. These walks use the node memory's single read port. Clear, and
// the pass after reset, sweep it one entry per cycle with the input not ready.
module node_reservation_lock_table
   import nrlt_pkg::*;
#(
   parameter int MAX_PATH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // robot_a[3:0], other_robot[7:4], node_id[15:8], node_valid[16]
   input  logic [23:0] req_tdata,
   // opcode[2:0]
   input  logic [2:0]  req_tuser,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // accepted[0], owner_valid[1], owner_robot[5:2], conflict[6],
   // deadlock[7], loser_robot[11:8], robots_active[16:12], nodes_held[25:17]
   output logic [31:0] rsp_tdata,
   // kind[2:0]
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_data
);

   logic [WIN_W-1:0] window_ff;
   logic             rsp_valid_ff, seq_valid, seq_ready;
   item_type         item;
   result_type       seq_result, rsp_ff;

   // Window register.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WIN_W'(16);
      end else if (csr_valid) begin
         window_ff <= csr_data;
      end
   end

   assign item.opcode      = req_tuser;
   assign item.robot_a     = req_tdata[3:0];
   assign item.other_robot = req_tdata[7:4];
   assign item.node_id     = req_tdata[15:8];
   assign item.node_valid  = req_tdata[16];
   assign item.last        = req_tlast;

   nrlt_seq #(.MAX_PATH(MAX_PATH)) u_seq (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_item(item),
      .window(window_ff),
      .out_valid(seq_valid), .out_ready(seq_ready), .out_result(seq_result)
   );

   // Result register.
   assign seq_ready = !rsp_valid_ff || rsp_tready;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (seq_ready) begin
         rsp_valid_ff <= seq_valid;
      end
   end
   always_ff @(posedge clock) begin
      if (seq_ready && seq_valid) begin
         rsp_ff <= seq_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.result_last;
   assign rsp_tdata  = {6'd0, rsp_ff.nodes_held, rsp_ff.robots_active,
                        rsp_ff.loser_robot, rsp_ff.deadlock, rsp_ff.conflict,
                        rsp_ff.owner_robot, rsp_ff.owner_valid, rsp_ff.accepted};

endmodule

// ----- sv/nrlt_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module nrlt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                        wdata,
   input  logic                                    re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                        rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule

// ----- sv/nrlt_seq.sv -----
// Sequencer of the lock table: walks the node and held-list memories to
// carry out each operation. Depends on nrlt_pkg, nrlt_ram and the macros.
`include "node_reservation_lock_table_macros.svh"

module nrlt_seq
   import nrlt_pkg::*;
#(
   parameter int MAX_PATH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  item_type         in_item,
   input  logic [WIN_W-1:0] window,
   output logic             out_valid,
   input  logic             out_ready,
   output result_type       out_result
);

   localparam int PW  = $clog2(MAX_PATH + 1);
   localparam int IW  = MAX_PATH > 1 ? $clog2(MAX_PATH) : 1;
   localparam int HAW = $clog2(ROBOTS * MAX_PATH);

   state_type state_ff, state_in;
   item_type  item_ff;
   logic [PW-1:0]      k_ff, path_len_ff;
   logic               path_conf_ff, ab_ff, ba_ff;
   logic [PW-1:0]      held_cnt_ff [ROBOTS];
   logic               present_ff [ROBOTS];
   logic [ACT_W-1:0]   active_ff;
   logic [TOT_W-1:0]   total_ff;
   logic [NODE_W-1:0]  buf_ff [MAX_PATH];
   logic [ROBOT_W-1:0] fr_ff;
   logic               to_commit_ff, clr_resp_ff;
   logic [NODE_W-1:0]  clr_addr_ff;
   logic               acc_ff, ownv_ff, conf_ff, dl_ff;
   logic [ROBOT_W-1:0] ownr_ff, loser_ff;

   logic               node_we, node_re, held_we, held_re;
   logic [NODE_W-1:0]  node_waddr, node_raddr;
   logic [ENTRY_W-1:0] node_wdata, node_rdata;
   logic [HAW-1:0]     held_waddr, held_raddr;
   logic [NODE_W-1:0]  held_rdata;

   logic               accept, nflag, held, push, ab_now;
   logic [ROBOT_W-1:0] nown, loser_now;
   logic [NODE_W-1:0]  buf_k;
   int                 w_sat;

   // Node table (flag and owner) and per-robot held lists.
   nrlt_ram #(.WIDTH(ENTRY_W), .DEPTH(NODES)) u_node_ram (
      .clock(clock), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
      .re(node_re), .raddr(node_raddr), .rdata(node_rdata)
   );

   nrlt_ram #(.WIDTH(NODE_W), .DEPTH(ROBOTS * MAX_PATH)) u_held_ram (
      .clock(clock), .we(held_we), .waddr(held_waddr), .wdata(buf_k),
      .re(held_re), .raddr(held_raddr), .rdata(held_rdata)
   );

   assign accept    = in_valid && in_ready;
   assign in_ready  = (state_ff == ST_IDLE);
   assign out_valid = (state_ff == ST_RESP);
   assign nflag     = node_rdata[ENTRY_W-1];
   assign nown      = node_rdata[ROBOT_W-1:0];
   assign held      = item_ff.node_valid && nflag;
   assign buf_k     = buf_ff[k_ff[IW-1:0]];
   assign w_sat     = (int'(window) > MAX_PATH) ? MAX_PATH : int'(window);
   assign push      = item_ff.node_valid && (int'(path_len_ff) < w_sat);
   assign ab_now    = ab_ff || (held && nown == item_ff.robot_a);
   assign loser_now = (item_ff.robot_a > item_ff.other_robot) ?
                      item_ff.robot_a : item_ff.other_robot;
   assign held_waddr = HAW'(item_ff.robot_a) * HAW'(MAX_PATH)
                     + HAW'(held_cnt_ff[item_ff.robot_a]);
   assign held_raddr = HAW'(fr_ff) * HAW'(MAX_PATH) + HAW'(k_ff);

   assign out_result.kind          = item_ff.opcode;
   assign out_result.accepted      = acc_ff;
   assign out_result.owner_valid   = ownv_ff;
   assign out_result.owner_robot   = ownr_ff;
   assign out_result.conflict      = conf_ff;
   assign out_result.deadlock      = dl_ff;
   assign out_result.loser_robot   = loser_ff;
   assign out_result.robots_active = active_ff;
   assign out_result.nodes_held    = total_ff;
   assign out_result.result_last   = item_ff.last;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and memory controls.
   always_comb begin
      state_in   = state_ff;
      node_we    = 1'b0;
      node_re    = 1'b0;
      held_we    = 1'b0;
      held_re    = 1'b0;
      node_waddr = buf_k;
      node_wdata = {1'b1, item_ff.robot_a};
      node_raddr = buf_k;
      unique case (state_ff)
         ST_CLEAR: begin
            node_we    = 1'b1;
            node_waddr = clr_addr_ff;
            node_wdata = '0;
            if (int'(clr_addr_ff) == NODES - 1) begin
               state_in = clr_resp_ff ? ST_RESP : ST_IDLE;
            end
         end
         ST_IDLE: begin
            node_raddr = in_item.node_id;
            if (accept) begin
               priority if (in_item.opcode == OP_CLEAR) begin
                  state_in = ST_CLEAR;
               end else if (in_item.opcode == OP_RELEASE) begin
                  state_in = ST_FREE_HL;
               end else if (in_item.opcode == OP_UNUSED) begin
                  state_in = ST_IDLE;
               end else begin
                  node_re  = 1'b1;
                  state_in = ST_LOOK;
               end
            end
         end
         ST_LOOK: begin
            unique case (item_ff.opcode)
               OP_RESERVE: state_in = item_ff.last ? ST_VER_RD : ST_IDLE;
               OP_QUERY,
               OP_CHECK:   state_in = ST_RESP;
               OP_DL_B: begin
                  if (!item_ff.last) begin
                     state_in = ST_IDLE;
                  end else if (ab_now && ba_ff) begin
                     state_in = ST_FREE_HL;
                  end else begin
                     state_in = ST_RESP;
                  end
               end
               default:    state_in = ST_IDLE;
            endcase
         end
         ST_VER_RD: begin
            if (path_conf_ff) begin
               state_in = ST_RESP;
            end else if (k_ff == path_len_ff) begin
               state_in = ST_FREE_HL;
            end else begin
               node_re  = 1'b1;
               state_in = ST_VER_CHK;
            end
         end
         ST_VER_CHK: begin
            if (nflag && nown != item_ff.robot_a) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_VER_RD;
            end
         end
         ST_FREE_HL: begin
            if (k_ff == held_cnt_ff[fr_ff]) begin
               state_in = to_commit_ff ? ST_COM_RD : ST_RESP;
            end else begin
               held_re  = 1'b1;
               state_in = ST_FREE_ND;
            end
         end
         ST_FREE_ND: begin
            node_re    = 1'b1;
            node_raddr = held_rdata;
            state_in   = ST_FREE_WR;
         end
         ST_FREE_WR: begin
            node_we    = nflag;
            node_waddr = held_rdata;
            node_wdata = {1'b0, nown};
            state_in   = ST_FREE_HL;
         end
         ST_COM_RD: begin
            if (k_ff == path_len_ff) begin
               state_in = ST_RESP;
            end else begin
               node_re  = 1'b1;
               state_in = ST_COM_WR;
            end
         end
         ST_COM_WR: begin
            if (!nflag && int'(held_cnt_ff[item_ff.robot_a]) < MAX_PATH) begin
               node_we = 1'b1;
               held_we = 1'b1;
            end
            state_in = ST_COM_RD;
         end
         ST_RESP: begin
            if (out_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control counters and flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         path_len_ff  <= '0;
         path_conf_ff <= 1'b0;
         ab_ff        <= 1'b0;
         ba_ff        <= 1'b0;
         active_ff    <= '0;
         total_ff     <= '0;
         clr_addr_ff  <= '0;
         clr_resp_ff  <= 1'b0;
         for (int r = 0; r < ROBOTS; r++) begin
            held_cnt_ff[r] <= '0;
            present_ff[r]  <= 1'b0;
         end
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
            end
            ST_IDLE: begin
               if (accept && in_item.opcode == OP_CLEAR) begin
                  clr_addr_ff <= '0;
                  clr_resp_ff <= 1'b1;
                  active_ff   <= '0;
                  total_ff    <= '0;
                  for (int r = 0; r < ROBOTS; r++) begin
                     held_cnt_ff[r] <= '0;
                     present_ff[r]  <= 1'b0;
                  end
               end
            end
            ST_LOOK: begin
               if (item_ff.opcode == OP_RESERVE && push) begin
                  path_len_ff <= path_len_ff + 1'b1;
                  if (held && nown != item_ff.robot_a) begin
                     path_conf_ff <= 1'b1;
                  end
               end
               if (item_ff.opcode == OP_DL_A && held && nown == item_ff.other_robot) begin
                  ba_ff <= 1'b1;
               end
               if (item_ff.opcode == OP_DL_B) begin
                  ab_ff <= item_ff.last ? 1'b0 : ab_now;
                  if (item_ff.last) begin
                     ba_ff <= 1'b0;
                  end
               end
            end
            ST_VER_RD: begin
               if (path_conf_ff) begin
                  path_len_ff  <= '0;
                  path_conf_ff <= 1'b0;
               end
            end
            ST_VER_CHK: begin
               if (nflag && nown != item_ff.robot_a) begin
                  path_len_ff  <= '0;
                  path_conf_ff <= 1'b0;
               end
            end
            ST_FREE_HL: begin
               if (k_ff == held_cnt_ff[fr_ff]) begin
                  held_cnt_ff[fr_ff] <= '0;
                  present_ff[fr_ff]  <= to_commit_ff;
                  if (present_ff[fr_ff] && !to_commit_ff) begin
                     active_ff <= active_ff - 1'b1;
                  end else if (!present_ff[fr_ff] && to_commit_ff) begin
                     active_ff <= active_ff + 1'b1;
                  end
               end
            end
            ST_FREE_WR: begin
               if (nflag) begin
                  total_ff <= total_ff - 1'b1;
               end
            end
            ST_COM_RD: begin
               if (k_ff == path_len_ff) begin
                  path_len_ff  <= '0;
                  path_conf_ff <= 1'b0;
               end
            end
            ST_COM_WR: begin
               if (held_we) begin
                  held_cnt_ff[item_ff.robot_a] <= held_cnt_ff[item_ff.robot_a] + 1'b1;
                  total_ff <= total_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Item, walk index, path buffer and result fields.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               item_ff      <= in_item;
               k_ff         <= '0;
               fr_ff        <= in_item.robot_a;
               to_commit_ff <= 1'b0;
               acc_ff       <= 1'b0;
               ownv_ff      <= 1'b0;
               ownr_ff      <= '0;
               conf_ff      <= 1'b0;
               dl_ff        <= 1'b0;
               loser_ff     <= '0;
            end
         end
         ST_LOOK: begin
            if (item_ff.opcode == OP_RESERVE && push) begin
               buf_ff[path_len_ff[IW-1:0]] <= item_ff.node_id;
            end
            ownv_ff <= (item_ff.opcode == OP_QUERY) && held;
            ownr_ff <= (item_ff.opcode == OP_QUERY && held) ? nown : '0;
            conf_ff <= (item_ff.opcode == OP_CHECK) && held
                       && nown != item_ff.robot_a;
            if (item_ff.opcode == OP_DL_B && item_ff.last && ab_now && ba_ff) begin
               dl_ff    <= 1'b1;
               loser_ff <= loser_now;
               fr_ff    <= loser_now;
            end
         end
         ST_VER_RD: begin
            if (!path_conf_ff && k_ff == path_len_ff) begin
               k_ff         <= '0;
               to_commit_ff <= 1'b1;
            end
         end
         ST_VER_CHK: begin
            k_ff <= k_ff + 1'b1;
         end
         ST_FREE_HL: begin
            if (k_ff == held_cnt_ff[fr_ff]) begin
               k_ff <= '0;
            end
         end
         ST_FREE_WR: begin
            k_ff <= k_ff + 1'b1;
         end
         ST_COM_RD: begin
            if (k_ff == path_len_ff) begin
               acc_ff <= 1'b1;
            end
         end
         ST_COM_WR: begin
            k_ff <= k_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   // The path is only verified, never written to the node table.
   `NRLT_ASSERT_IMP(a_ver_no_write, clock, reset,
      state_ff == ST_VER_RD || state_ff == ST_VER_CHK, !node_we && !held_we)
   // The owned-node count cannot exceed the table size.
   `NRLT_ASSERT_IMP(a_total_bound, clock, reset, 1'b1, int'(total_ff) <= NODES)
   // A taken result frees the sequencer for the next transaction.
   `NRLT_ASSERT_NXT(a_resp_done, clock, reset,
      state_ff == ST_RESP && out_ready, state_ff == ST_IDLE)

endmodule
